### sv/pbl_pkg.sv
package pbl_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned DIM_W       = 13;
  localparam int unsigned COORD_W     = 12;
  localparam int unsigned COLOR_W     = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned INDEX_W     = 16;
  localparam int unsigned PAL_AW      = 8;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned STEP_W      = 29;
  localparam int unsigned ACC_W       = 32;
  localparam int unsigned DIV_CNT_W   = 5;

  typedef logic [1:0]             req_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;
  typedef logic [DIM_W-1:0]       dim_t;
  typedef logic [COORD_W-1:0]     coord_t;
  typedef logic [COLOR_W-1:0]     color_t;
  typedef logic [BYTE_W-1:0]      byte_t;
  typedef logic [INDEX_W-1:0]     index_t;

  localparam req_t REQ_LOAD_SRC = 2'd0;
  localparam req_t REQ_LOAD_PAL = 2'd1;
  localparam req_t REQ_START    = 2'd2;
  localparam req_t REQ_DRAW     = 2'd3;

  localparam cfg_index_t CFG_SRC_WIDTH  = 3'd0;
  localparam cfg_index_t CFG_SRC_HEIGHT = 3'd1;
  localparam cfg_index_t CFG_TGT_X      = 3'd2;
  localparam cfg_index_t CFG_TGT_Y      = 3'd3;
  localparam cfg_index_t CFG_TGT_WIDTH  = 3'd4;
  localparam cfg_index_t CFG_TGT_HEIGHT = 3'd5;
  localparam cfg_index_t CFG_SCR_WIDTH  = 3'd6;
  localparam cfg_index_t CFG_SCR_HEIGHT = 3'd7;

  localparam dim_t SCR_WIDTH_RST  = 13'd640;
  localparam dim_t SCR_HEIGHT_RST = 13'd480;

endpackage

### sv/palette_stretch_blitter.sv
// load items write memory on accept. draw item: the result strobe follows the registered
// source read, then the palette read; busy holds off new items until the palette read.
// a start item with a non-empty clip is busy for the 29-step column step division; a draw
// ending a row other than the last adds busy states: multiply, 29-step row divide, base
// multiply. the receiver cannot stall. async active-low reset clears control and config
// registers; source and palette memories are not cleared and hold garbage until written.
module palette_stretch_blitter #(
  parameter int unsigned SOURCE_DEPTH = 65536
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  pbl_pkg::req_t        req_type_i,
  input  pbl_pkg::index_t      entry_index_i,
  input  pbl_pkg::byte_t       byte_value_i,
  input  pbl_pkg::color_t      color_value_i,
  input  logic                 cfg_we_i,
  input  pbl_pkg::cfg_index_t  cfg_index_i,
  input  pbl_pkg::cfg_data_t   cfg_data_i,
  output logic                 result_valid_o,
  output pbl_pkg::coord_t      pixel_x_o,
  output pbl_pkg::coord_t      pixel_y_o,
  output pbl_pkg::color_t      pixel_color_o,
  output logic                 last_pixel_o
);
  import pbl_pkg::*;

  localparam int unsigned AW     = $clog2(SOURCE_DEPTH);
  localparam int unsigned PROD_W = 2 * DIM_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_BASE = 2'd3;

  // config registers
  dim_t   src_w_q, src_h_q, tgt_w_q, tgt_h_q, scr_w_q, scr_h_q;
  coord_t tgt_x_q, tgt_y_q;

  // drawing state
  dim_t              clip_w_q, clip_h_q, col_q, row_q;
  logic [STEP_W-1:0] step_q;
  logic [ACC_W-1:0]  acc_q;
  logic [AW-1:0]     row_base_q;
  logic              active_q;
  logic [1:0]        state_q;

  // divider
  logic [STEP_W-1:0]    div_num_q;
  dim_t                 div_rem_q, div_den_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic                 div_row_q;

  // pipeline
  logic   s1_valid_q, s1_last_q, out_valid_q, out_last_q;
  coord_t s1_x_q, s1_y_q, out_x_q, out_y_q;
  byte_t  src_rd_q;
  color_t pal_rd_q;

  byte_t  src_mem [SOURCE_DEPTH];
  color_t pal_mem [2**PAL_AW];

  logic          accept, draw_go, row_end, rect_end;
  dim_t          clip_w, clip_h, col_inc, row_inc;
  logic [13:0]   x_span, y_span;
  logic [AW-1:0] rd_addr;
  logic [13:0]   rem_sh;
  logic          rem_ge;
  dim_t          rem_next;
  logic [PROD_W-1:0] row_prod;

  assign accept  = start_i & ~busy_o;
  assign draw_go = accept & (req_type_i == REQ_DRAW) & active_q;
  assign busy_o  = (state_q != S_IDLE) | s1_valid_q;

  assign row_prod = PROD_W'(div_num_q[DIM_W-1:0]) * PROD_W'(src_w_q);

  always_comb begin
    x_span = {2'b00, tgt_x_q} + {1'b0, tgt_w_q};
    y_span = {2'b00, tgt_y_q} + {1'b0, tgt_h_q};
    if ({1'b0, tgt_x_q} >= scr_w_q) begin
      clip_w = '0;
    end else if (x_span > {1'b0, scr_w_q}) begin
      clip_w = scr_w_q - {1'b0, tgt_x_q};
    end else begin
      clip_w = tgt_w_q;
    end
    if ({1'b0, tgt_y_q} >= scr_h_q) begin
      clip_h = '0;
    end else if (y_span > {1'b0, scr_h_q}) begin
      clip_h = scr_h_q - {1'b0, tgt_y_q};
    end else begin
      clip_h = tgt_h_q;
    end
  end

  always_comb begin
    col_inc  = col_q + 13'd1;
    row_inc  = row_q + 13'd1;
    row_end  = (col_inc >= clip_w_q);
    rect_end = (row_inc >= clip_h_q);
    rd_addr  = row_base_q + AW'(acc_q[ACC_W-1:FRAC_W]);
  end

  // one restoring division step
  always_comb begin
    rem_sh = {div_rem_q, div_num_q[STEP_W-1]};
    rem_ge = (rem_sh >= {1'b0, div_den_q});
    if (rem_ge) begin
      rem_next = DIM_W'(rem_sh - {1'b0, div_den_q});
    end else begin
      rem_next = rem_sh[DIM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q     <= 13'd1;
      src_h_q     <= 13'd1;
      tgt_x_q     <= '0;
      tgt_y_q     <= '0;
      tgt_w_q     <= '0;
      tgt_h_q     <= '0;
      scr_w_q     <= SCR_WIDTH_RST;
      scr_h_q     <= SCR_HEIGHT_RST;
      clip_w_q    <= '0;
      clip_h_q    <= '0;
      step_q      <= '0;
      acc_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      row_base_q  <= '0;
      active_q    <= 1'b0;
      state_q     <= S_IDLE;
      div_row_q   <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= draw_go;
      out_valid_q <= s1_valid_q;

      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SRC_WIDTH:  src_w_q <= cfg_data_i;
          CFG_SRC_HEIGHT: src_h_q <= cfg_data_i;
          CFG_TGT_X:      tgt_x_q <= cfg_data_i[COORD_W-1:0];
          CFG_TGT_Y:      tgt_y_q <= cfg_data_i[COORD_W-1:0];
          CFG_TGT_WIDTH:  tgt_w_q <= cfg_data_i;
          CFG_TGT_HEIGHT: tgt_h_q <= cfg_data_i;
          CFG_SCR_WIDTH:  scr_w_q <= cfg_data_i;
          CFG_SCR_HEIGHT: scr_h_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (accept && req_type_i == REQ_START) begin
        clip_w_q   <= clip_w;
        clip_h_q   <= clip_h;
        acc_q      <= '0;
        col_q      <= '0;
        row_q      <= '0;
        row_base_q <= '0;
        if (clip_w != '0 && clip_h != '0) begin
          active_q  <= 1'b1;
          div_row_q <= 1'b0;
          state_q   <= S_DIV;
        end else begin
          active_q <= 1'b0;
          step_q   <= '0;
        end
      end

      if (draw_go) begin
        if (row_end) begin
          col_q <= '0;
          acc_q <= '0;
          if (rect_end) begin
            active_q   <= 1'b0;
            row_q      <= '0;
            row_base_q <= '0;
          end else begin
            row_q     <= row_inc;
            div_row_q <= 1'b1;
            state_q   <= S_MUL;
          end
        end else begin
          col_q <= col_inc;
          acc_q <= acc_q + ACC_W'(step_q);
        end
      end

      case (state_q)
        S_IDLE: ;
        S_MUL:  state_q <= S_DIV;
        S_DIV: begin
          if (div_cnt_q == '0) begin
            state_q <= S_BASE;
          end
        end
        S_BASE: begin
          if (div_row_q) begin
            row_base_q <= AW'(row_prod);
          end else begin
            step_q <= div_num_q;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // divider datapath and result pipeline payload
  always_ff @(posedge clk_i) begin
    if (accept && req_type_i == REQ_START) begin
      div_num_q <= {src_w_q, FRAC_W'(0)};
      div_rem_q <= '0;
      div_den_q <= clip_w;
      div_cnt_q <= DIV_CNT_W'(STEP_W - 1);
    end else if (state_q == S_MUL) begin
      div_num_q <= STEP_W'(row_q) * STEP_W'(src_h_q);
      div_rem_q <= '0;
      div_den_q <= clip_h_q;
      div_cnt_q <= DIV_CNT_W'(STEP_W - 1);
    end else if (state_q == S_DIV) begin
      div_num_q <= {div_num_q[STEP_W-2:0], rem_ge};
      div_rem_q <= rem_next;
      div_cnt_q <= div_cnt_q - 1'b1;
    end

    if (draw_go) begin
      s1_x_q    <= COORD_W'(tgt_x_q + col_q);
      s1_y_q    <= COORD_W'(tgt_y_q + row_q);
      s1_last_q <= row_end & rect_end;
    end
    out_x_q    <= s1_x_q;
    out_y_q    <= s1_y_q;
    out_last_q <= s1_last_q;
  end

  always_ff @(posedge clk_i) begin
    if (accept && req_type_i == REQ_LOAD_SRC) begin
      src_mem[AW'(entry_index_i)] <= byte_value_i;
    end
    if (draw_go) begin
      src_rd_q <= src_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && req_type_i == REQ_LOAD_PAL) begin
      pal_mem[entry_index_i[PAL_AW-1:0]] <= color_value_i;
    end
    if (s1_valid_q) begin
      pal_rd_q <= pal_mem[src_rd_q];
    end
  end

  assign result_valid_o = out_valid_q;
  assign pixel_x_o      = out_x_q;
  assign pixel_y_o      = out_y_q;
  assign pixel_color_o  = pal_rd_q;
  assign last_pixel_o   = out_last_q;

`ifndef SYNTHESIS
  a_result_from_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o && req_type_i == REQ_DRAW && active_q, 2))
    else $error("result without an accepted draw item");

  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (div_rem_q < div_den_q))
    else $error("divider remainder out of range");

  a_last_ends_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_pixel_o) |-> !active_q)
    else $error("drawing still active after last pixel");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

import pbl_pkg::*;

localparam int unsigned SRC_DEPTH = 65536;
localparam int unsigned PAL_SIZE  = 1 << PAL_AW;

typedef struct packed {
  coord_t x;
  coord_t y;
  color_t color;
  logic   last;
} pixel_t;

class pixel_scoreboard;
  dim_t               regs [1 << CFG_INDEX_W];
  byte_t              src_mem [SRC_DEPTH];
  bit                 src_set [SRC_DEPTH];
  color_t             pal_mem [PAL_SIZE];
  bit                 pal_set [PAL_SIZE];
  int unsigned        clip_w, clip_h, col_cnt, row_cnt, row_base;
  logic [STEP_W-1:0]  col_step;
  logic [ACC_W-1:0]   col_acc;
  bit                 active;
  pixel_t             expected_pixels [$];
  int                 mismatches;

  function new();
    regs[CFG_SRC_WIDTH]  = 13'd1;
    regs[CFG_SRC_HEIGHT] = 13'd1;
    regs[CFG_TGT_X]      = 13'd0;
    regs[CFG_TGT_Y]      = 13'd0;
    regs[CFG_TGT_WIDTH]  = 13'd0;
    regs[CFG_TGT_HEIGHT] = 13'd0;
    regs[CFG_SCR_WIDTH]  = SCR_WIDTH_RST;
    regs[CFG_SCR_HEIGHT] = SCR_HEIGHT_RST;
    clip_w     = 0;
    clip_h     = 0;
    col_cnt    = 0;
    row_cnt    = 0;
    row_base   = 0;
    col_step   = '0;
    col_acc    = '0;
    active     = 1'b0;
    mismatches = 0;
  endfunction

  function void write_reg(cfg_index_t index, cfg_data_t value);
    if (index == CFG_TGT_X || index == CFG_TGT_Y) begin
      regs[index] = {1'b0, value[COORD_W-1:0]};
    end else begin
      regs[index] = value;
    end
  endfunction

  function int unsigned clip_span(int unsigned origin, int unsigned extent, int unsigned limit);
    if (origin >= limit) return 0;
    if (origin + extent > limit) return limit - origin;
    return extent;
  endfunction

  function void next_row_base();
    longint unsigned src_row;
    src_row = row_cnt;
    src_row = (src_row * regs[CFG_SRC_HEIGHT]) / clip_h;
    row_base = int'((src_row * regs[CFG_SRC_WIDTH]) % SRC_DEPTH);
  endfunction

  // source address the next draw reads, -1 while idle
  function int read_addr();
    if (!active) return -1;
    return int'((row_base + col_acc[ACC_W-1:FRAC_W]) % SRC_DEPTH);
  endfunction

  // returns 0 for an item the block ignores
  function bit accept_item(req_t req, index_t idx, byte_t value, color_t color);
    pixel_t          px;
    int              addr;
    longint unsigned wide;
    if (req == REQ_LOAD_SRC) begin
      src_mem[idx % SRC_DEPTH] = value;
      src_set[idx % SRC_DEPTH] = 1'b1;
      return 1'b1;
    end
    if (req == REQ_LOAD_PAL) begin
      pal_mem[idx[PAL_AW-1:0]] = color;
      pal_set[idx[PAL_AW-1:0]] = 1'b1;
      return 1'b1;
    end
    if (req == REQ_START) begin
      clip_w   = clip_span(regs[CFG_TGT_X], regs[CFG_TGT_WIDTH], regs[CFG_SCR_WIDTH]);
      clip_h   = clip_span(regs[CFG_TGT_Y], regs[CFG_TGT_HEIGHT], regs[CFG_SCR_HEIGHT]);
      col_acc  = '0;
      col_cnt  = 0;
      row_cnt  = 0;
      row_base = 0;
      if (clip_w != 0 && clip_h != 0) begin
        wide     = regs[CFG_SRC_WIDTH];
        wide     = (wide << FRAC_W) / clip_w;
        col_step = STEP_W'(wide);
        active   = 1'b1;
      end else begin
        col_step = '0;
        active   = 1'b0;
      end
      return 1'b1;
    end
    if (!active) return 1'b0;
    addr     = read_addr();
    px.x     = coord_t'(regs[CFG_TGT_X] + col_cnt);
    px.y     = coord_t'(regs[CFG_TGT_Y] + row_cnt);
    px.color = pal_mem[src_mem[addr]];
    px.last  = (col_cnt + 1 == clip_w) && (row_cnt + 1 == clip_h);
    expected_pixels.push_back(px);
    col_cnt++;
    col_acc = col_acc + ACC_W'(col_step);
    if (col_cnt >= clip_w) begin
      col_cnt = 0;
      col_acc = '0;
      row_cnt++;
      if (row_cnt >= clip_h) begin
        active   = 1'b0;
        row_cnt  = 0;
        row_base = 0;
      end else begin
        next_row_base();
      end
    end
    return 1'b1;
  endfunction

  function void check_pixel(coord_t x, coord_t y, color_t color, logic last);
    pixel_t want;
    if (expected_pixels.size() == 0) begin
      $display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%b", $time, x, y, color, last);
      mismatches++;
      return;
    end
    want = expected_pixels.pop_front();
    if (x !== want.x) begin
      $display("%0t: pixel_x expected %0d actual %0d", $time, want.x, x);
      mismatches++;
    end
    if (y !== want.y) begin
      $display("%0t: pixel_y expected %0d actual %0d", $time, want.y, y);
      mismatches++;
    end
    if (color !== want.color) begin
      $display("%0t: pixel_color expected %h actual %h", $time, want.color, color);
      mismatches++;
    end
    if (last !== want.last) begin
      $display("%0t: last_pixel expected %b actual %b", $time, want.last, last);
      mismatches++;
    end
  endfunction
endclass

module testbench;

  localparam int CLK_PERIOD  = 10;
  localparam int SETTLE      = 40;
  localparam int DRAIN_LIMIT = 2000;
  localparam int ITEM_GOAL   = 1000;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       start_i;
  logic       busy_o;
  req_t       req_type_i;
  index_t     entry_index_i;
  byte_t      byte_value_i;
  color_t     color_value_i;
  logic       cfg_we_i;
  cfg_index_t cfg_index_i;
  cfg_data_t  cfg_data_i;
  logic       result_valid_o;
  coord_t     pixel_x_o;
  coord_t     pixel_y_o;
  color_t     pixel_color_o;
  logic       last_pixel_o;

  pixel_scoreboard pixels;
  int              n_items;
  bit              gaps_on;
  int              phase;

  palette_stretch_blitter #(
    .SOURCE_DEPTH(SRC_DEPTH)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .req_type_i    (req_type_i),
    .entry_index_i (entry_index_i),
    .byte_value_i  (byte_value_i),
    .color_value_i (color_value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .result_valid_o(result_valid_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .last_pixel_o  (last_pixel_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      pixels.check_pixel(pixel_x_o, pixel_y_o, pixel_color_o, last_pixel_o);
    end
  end

  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  task automatic send_item(req_t req, index_t idx, byte_t value, color_t color);
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 13) begin
        start_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    start_i       <= 1'b1;
    req_type_i    <= req;
    entry_index_i <= idx;
    byte_value_i  <= value;
    color_value_i <= color;
    do @(posedge clk_i); while (busy_o);
    if (pixels.accept_item(req, idx, value, color)) n_items++;
  endtask

  task automatic send_start();
    send_item(REQ_START, index_t'($urandom), byte_t'($urandom), color_t'($urandom));
  endtask

  task automatic random_load();
    if ($urandom_range(0, 1) == 0) begin
      send_item(REQ_LOAD_SRC, index_t'($urandom), byte_t'($urandom), color_t'($urandom));
    end else begin
      send_item(REQ_LOAD_PAL, index_t'($urandom), byte_t'($urandom), color_t'($urandom));
    end
  endtask

  // fills in whatever the next draw would read before issuing it
  task automatic draw_pixel();
    int    addr;
    byte_t b;
    addr = pixels.read_addr();
    if (addr >= 0) begin
      if (!pixels.src_set[addr]) begin
        send_item(REQ_LOAD_SRC, index_t'(addr), byte_t'($urandom), color_t'($urandom));
      end
      b = pixels.src_mem[addr];
      if (!pixels.pal_set[b]) begin
        send_item(REQ_LOAD_PAL, {byte_t'($urandom), b}, byte_t'($urandom), color_t'($urandom));
      end
    end
    send_item(REQ_DRAW, index_t'($urandom), byte_t'($urandom), color_t'($urandom));
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    start_i <= 1'b0;
    while (pixels.expected_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic program_regs(dim_t sw, dim_t sh, dim_t tx, dim_t ty,
                              dim_t tw, dim_t th, dim_t scw, dim_t sch);
    dim_t vals [1 << CFG_INDEX_W];
    drain();
    vals[CFG_SRC_WIDTH]  = sw;
    vals[CFG_SRC_HEIGHT] = sh;
    vals[CFG_TGT_X]      = tx;
    vals[CFG_TGT_Y]      = ty;
    vals[CFG_TGT_WIDTH]  = tw;
    vals[CFG_TGT_HEIGHT] = th;
    vals[CFG_SCR_WIDTH]  = scw;
    vals[CFG_SCR_HEIGHT] = sch;
    for (int i = 0; i < (1 << CFG_INDEX_W); i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= cfg_index_t'(i);
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      pixels.write_reg(cfg_index_t'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase();
    int unsigned kind, cap, drawn, tx, ty;
    dim_t        sw, sh, tw, th, scw, sch;
    kind = $urandom_range(0, 9);
    tx   = $urandom_range(0, 4095);
    ty   = $urandom_range(0, 4095);
    scw  = 13'd4096;
    sch  = 13'd4096;
    if (kind == 0) begin
      // extremes: huge rectangles, only partly drawn
      sw = ($urandom_range(0, 1) == 0) ? 13'd1 : 13'd4096;
      sh = ($urandom_range(0, 1) == 0) ? 13'd1 : 13'd4096;
      tx = ($urandom_range(0, 1) == 0) ? 0 : 4095;
      ty = ($urandom_range(0, 1) == 0) ? 0 : 4095;
      tw = 13'd4096;
      th = 13'd4096;
    end else if (kind == 1) begin
      // empty rectangle
      sw = dim_t'($urandom_range(1, 16));
      sh = dim_t'($urandom_range(1, 16));
      tw = ($urandom_range(0, 1) == 0) ? 13'd0 : 13'd5;
      th = (tw == 13'd0) ? 13'd5 : 13'd0;
    end else begin
      sw  = dim_t'($urandom_range(1, 12));
      sh  = dim_t'($urandom_range(1, 12));
      tw  = dim_t'($urandom_range(1, 16));
      th  = dim_t'($urandom_range(1, 8));
      scw = dim_t'((tx + $urandom_range(0, 20) > 4096) ? 4096 : tx + $urandom_range(0, 20));
      sch = dim_t'((ty + $urandom_range(0, 12) > 4096) ? 4096 : ty + $urandom_range(0, 12));
    end
    program_regs(sw, sh, dim_t'(tx), dim_t'(ty), tw, th, scw, sch);
    repeat ($urandom_range(0, 3)) random_load();
    if ($urandom_range(0, 4) == 0) draw_pixel();
    send_start();
    cap   = (kind == 0 || $urandom_range(0, 5) == 0) ? $urandom_range(1, 40) : 400;
    drawn = 0;
    while (pixels.active && drawn < cap) begin
      if ($urandom_range(0, 39) == 0) begin
        send_start();
      end else if ($urandom_range(0, 14) == 0) begin
        random_load();
      end
      draw_pixel();
      drawn++;
    end
    if ($urandom_range(0, 3) == 0) draw_pixel();
  endtask

  initial begin
    pixels        = new();
    n_items       = 0;
    gaps_on       = 1'b1;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    req_type_i    = REQ_LOAD_SRC;
    entry_index_i = '0;
    byte_value_i  = '0;
    color_value_i = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_SRC_WIDTH;
    cfg_data_i    = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // draws while idle and an empty start under reset settings
    draw_pixel();
    send_start();
    draw_pixel();
    send_item(REQ_LOAD_SRC, 16'hffff, 8'hff, 16'h0000);
    send_item(REQ_LOAD_PAL, 16'hffff, 8'h00, 16'hffff);
    send_item(REQ_LOAD_SRC, 16'h0000, 8'h00, 16'hffff);
    send_item(REQ_LOAD_PAL, 16'h0000, 8'hff, 16'h0000);

    // small stretch, full rectangle
    program_regs(13'd2, 13'd2, 13'd3, 13'd5, 13'd3, 13'd3, 13'd640, 13'd480);
    send_start();
    repeat (9) draw_pixel();

    // target beyond the right edge
    program_regs(13'd1, 13'd1, 13'd700, 13'd0, 13'd4, 13'd4, 13'd640, 13'd480);
    send_start();
    draw_pixel();

    // clipped at the far corner, restarted while drawing
    program_regs(13'd3, 13'd1, 13'd4094, 13'd4095, 13'd5, 13'd2, 13'd4096, 13'd4096);
    send_start();
    draw_pixel();
    send_start();
    draw_pixel();
    draw_pixel();

    phase = 0;
    while (n_items < ITEM_GOAL) begin
      gaps_on = !(phase >= 3 && phase < 6);
      random_phase();
      phase++;
    end

    drain();
    if (pixels.expected_pixels.size() != 0) begin
      $display("%0t: %0d expected pixels never arrived", $time, pixels.expected_pixels.size());
      pixels.mismatches++;
    end
    if (pixels.mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

### palette_stretch_blitter.f
sv/pbl_pkg.sv
sv/palette_stretch_blitter.sv
tb/testbench.sv
